// ===== hw/rtl/signed_int_to_decimal_ascii_defines.svh =====
// Assertion macros for the top-level RTL file of the decimal text converter.
// No dependencies; included by modules that carry concurrent checks.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SITOA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SITOA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sitoa_pkg.sv =====
// Types and constants for the signed integer to decimal ASCII converter.
// No dependencies; imported by the interfaces and all modules.
package sitoa_pkg;

  localparam int VALUE_BITS = 32;
  localparam int FIELD_W    = 32;
  localparam int CHAR_W     = 8;

  // Decimal digits needed for 2^(VALUE_BITS-1).
  localparam int NUM_DIGITS = (VALUE_BITS * 77) / 256 + 1;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // Add-3 correction for a radix-10 digit before each doubling.
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;
  localparam logic [3:0] BCD_MAX     = 4'd9;

  typedef struct packed {
    logic                  load;
    logic [VALUE_BITS-1:0] mag;
  } dd_ctrl_t;

  typedef struct packed {
    logic busy;
  } dd_stat_t;

endpackage

// ===== hw/rtl/sitoa_if.sv =====
// Valid/ready channel interfaces for the converter's input and result beats.
// Depends on sitoa_pkg for field widths.
interface sitoa_in_if
  import sitoa_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_out_if
  import sitoa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              is_last;

  modport source (output valid, output text_char, output is_last, input ready);
  modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

// ===== hw/rtl/sitoa_dabble.sv =====
// Shift-and-add-3 unit: turns a binary magnitude into packed BCD,
// one bit per cycle. Depends on sitoa_pkg.
module sitoa_dabble
  import sitoa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dd_ctrl_t         ctrl,
  output dd_stat_t         stat,
  output logic [BCD_W-1:0] bcd
);

  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= BCD_ADJ_MIN) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + BCD_ADJ_ADD;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      bin_nxt = ctrl.mag;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(VALUE_BITS);
    end else if (cnt_r != '0) begin
      {bcd_nxt, bin_nxt} = {adj, bin_r} << 1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.busy = (cnt_r != '0);
  assign bcd       = bcd_r;

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter: sequencer,
// digit selection and output register. Depends on sitoa_pkg, sitoa_if,
// sitoa_dabble and the assertion macro header.
//
//   channel   | direction | beat contents
//   ----------+-----------+------------------------------------------
//   in_chan   | sink      | value: signed 32-bit integer
//   out_chan  | source    | text_char: ASCII character, is_last flag
//
// After an input beat the shift-and-add-3 unit works through all VALUE_BITS bits,
// then the sequencer locates the leading digit, then characters leave one per
// cycle unless the output stalls.
// Reset is synchronous and active low; it clears the sequencer and output valid.
// A stalled output holds its beat and pauses the character sequence.
// A new input is taken as soon as the last character sits in the output register.
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii
  import sitoa_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  sitoa_in_if.sink    in_chan,
  sitoa_out_if.source out_chan
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  state_t                state_r;
  logic                  sign_pend_r;
  logic [DIG_IDX_W-1:0]  idx_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r;
  logic                  out_last_r;

  logic [VALUE_BITS-1:0] raw;
  logic                  in_neg;
  logic                  in_fire;
  logic                  out_free;
  logic [BCD_W-1:0]      bcd;
  logic [3:0]            digit_sel;
  logic [DIG_IDX_W-1:0]  lead_idx;
  dd_ctrl_t              dd_ctrl;
  dd_stat_t              dd_stat;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign raw    = VALUE_BITS'(in_chan.value);
  assign in_neg = raw[VALUE_BITS-1];

  // Negating the most negative value wraps to itself, which read unsigned
  // is exactly its magnitude.
  assign dd_ctrl.load = in_fire;
  assign dd_ctrl.mag  = in_neg ? (~raw + 1'b1) : raw;

  sitoa_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (dd_ctrl),
    .stat  (dd_stat),
    .bcd   (bcd)
  );

  // Highest nonzero digit; zero itself leaves index 0 so one '0' goes out.
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        lead_idx = DIG_IDX_W'(i);
      end
    end
  end

  assign digit_sel = bcd[idx_r*4 +: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sign_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // While emitting, a taken beat is always replaced by the next one below.
      if (out_valid_r && out_chan.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            sign_pend_r <= in_neg;
            state_r     <= S_CONV;
          end
        end
        S_CONV: begin
          if (!dd_stat.busy) begin
            idx_r   <= lead_idx;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (sign_pend_r) begin
              out_char_r  <= CHAR_MINUS;
              out_last_r  <= 1'b0;
              sign_pend_r <= 1'b0;
            end else begin
              out_char_r <= CHAR_ZERO + CHAR_W'(digit_sel);
              out_last_r <= (idx_r == '0);
              if (idx_r == '0) begin
                state_r <= S_IDLE;
              end else begin
                idx_r <= idx_r - 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.text_char = out_char_r;
  assign out_chan.is_last   = out_last_r;

  `SITOA_ASSERT_NEXT(a_load_starts_unit, in_fire, dd_stat.busy, "shift unit idle after input beat")
  `SITOA_ASSERT_NOW(a_idle_unit_quiet, state_r == S_IDLE, !dd_stat.busy, "shift unit busy while idle")
  `SITOA_ASSERT_NOW(a_digit_in_range, state_r == S_EMIT && !sign_pend_r, digit_sel <= BCD_MAX, "selected BCD digit above nine")

endmodule
